// ===== rtl/core/smx_pkg.sv =====
`timescale 1ns / 1ps

package smx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 5;
    localparam int KIND_W      = 3;
    localparam int SEL_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int NUM_REGS    = 3;
    localparam int CNT_W       = $clog2(DATA_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_HALT     = 3'd0,
        KIND_PUSH_IMM = 3'd1,
        KIND_PUSH_REG = 3'd2,
        KIND_POP_REG  = 3'd3,
        KIND_POP_DROP = 3'd4,
        KIND_ADD      = 3'd5,
        KIND_SUB      = 3'd6,
        KIND_DIV      = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_HALT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_DIV = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

// ===== rtl/core/smx_if.sv =====
`timescale 1ns / 1ps

interface smx_cmd_if import smx_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [SEL_W-1:0]         reg_sel;
    logic signed [DATA_W-1:0] immediate;

    modport source (output valid, kind, reg_sel, immediate, input ready);
    modport sink   (input valid, kind, reg_sel, immediate, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, top_value, stack_depth, status, input ready);
    modport sink   (input valid, top_value, stack_depth, status, output ready);
endinterface

// ===== rtl/core/smx_alu.sv =====
`timescale 1ns / 1ps

module smx_alu import smx_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] top,
    input  logic [DATA_W-1:0] next,
    output alu_rsp_t          rsp
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX
    } alu_state_t;

    alu_state_t        state_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] res_reg;
    logic              done_reg;

    logic [DATA_W:0]   add_a;
    logic [DATA_W:0]   add_b;
    logic              add_sub;
    logic [DATA_W:0]   sum;

    // one shared adder: add, subtract, trial subtract, final negate
    always_comb
    begin
        add_a   = {1'b0, next};
        add_b   = {1'b0, top};
        add_sub = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                add_sub = (req.op == ALU_SUB);
            end
            A_DIV:
            begin
                add_a   = {rem_reg, quo_reg[DATA_W-1]};
                add_b   = {1'b0, den_reg};
                add_sub = 1'b1;
            end
            A_FIX:
            begin
                add_a   = '0;
                add_b   = {1'b0, quo_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        sum = add_a + (add_sub ? ~add_b : add_b) + {{DATA_W{1'b0}}, add_sub};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                A_IDLE:
                begin
                    done_reg <= req.start && (req.op != ALU_DIV);
                    if (req.start)
                    begin
                        if (req.op == ALU_DIV)
                        begin
                            rem_reg   <= '0;
                            quo_reg   <= top[DATA_W-1] ? (~top + 1'b1) : top;
                            den_reg   <= next[DATA_W-1] ? (~next + 1'b1) : next;
                            neg_reg   <= top[DATA_W-1] ^ next[DATA_W-1];
                            cnt_reg   <= '0;
                            state_reg <= A_DIV;
                        end
                        else
                        begin
                            res_reg <= sum[DATA_W-1:0];
                        end
                    end
                end
                A_DIV:
                begin
                    done_reg <= 1'b0;
                    if (!sum[DATA_W])
                    begin
                        rem_reg <= sum[DATA_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                    end
                    quo_reg <= {quo_reg[DATA_W-2:0], ~sum[DATA_W]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DATA_W - 1))
                    begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX:
                begin
                    res_reg   <= neg_reg ? sum[DATA_W-1:0] : quo_reg;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== rtl/core/stack_machine_execute.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Payload                              | Handshake
// cmd     | in  | kind, reg_sel, immediate             | valid/ready
// rsp     | out | top_value, stack_depth, status       | valid/ready
//
// Push, pop and halt finish in the execute state; add and sub also pass through
// the ALU and write-back states. Divide runs 32 restoring steps through the
// shared adder in the ALU, plus operand setup, sign fixup and write-back.
// One request at a time; cmd is ready only when the sequencer is idle.
// A finished result sits in the output register; if it has not been taken,
// the next result holds in the sequencer until it is. Reset clears the stack
// pointer, the general registers and the halted flag.

module stack_machine_execute import smx_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    smx_cmd_if.sink  cmd,
    smx_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ALU,
        S_WB
    } seq_state_t;

    seq_state_t               state_reg;
    kind_t                    kind_reg;
    logic [SEL_W-1:0]         sel_reg;
    logic [DATA_W-1:0]        imm_reg;
    logic [SP_W-1:0]          sp_reg;
    logic                     halted_reg;
    logic [DATA_W-1:0]        gp_reg [NUM_REGS];
    logic [DATA_W-1:0]        top_rd_reg;
    logic [DATA_W-1:0]        next_rd_reg;

    logic                     rsp_valid_reg;
    logic [DATA_W-1:0]        rsp_top_reg;
    logic [DEPTH_W-1:0]       rsp_depth_reg;
    status_t                  rsp_status_reg;

    logic [DATA_W-1:0]        stack_mem [STACK_DEPTH];

    logic                     cmd_fire;
    logic                     out_free;
    logic [ADDR_W-1:0]        addr_top;
    logic [ADDR_W-1:0]        addr_next;

    logic                     commit;
    logic                     go_alu;
    status_t                  st_next;
    logic [SP_W-1:0]          sp_next;
    logic [DATA_W-1:0]        top_next;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic                     gp_we;
    logic                     halt_set;
    logic [DATA_W-1:0]        push_val;

    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign addr_top  = sp_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign addr_next = sp_reg[ADDR_W-1:0] - ADDR_W'(2);

    assign push_val = (kind_reg == KIND_PUSH_REG)
                    ? ((sel_reg < SEL_W'(NUM_REGS)) ? gp_reg[sel_reg] : '0)
                    : imm_reg;

    smx_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .top   (top_rd_reg),
        .next  (next_rd_reg),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        commit    = 1'b0;
        go_alu    = 1'b0;
        st_next   = ST_OK;
        sp_next   = sp_reg;
        top_next  = (sp_reg != '0) ? top_rd_reg : '0;
        mem_we    = 1'b0;
        mem_waddr = sp_reg[ADDR_W-1:0];
        mem_wdata = push_val;
        gp_we     = 1'b0;
        halt_set  = 1'b0;
        alu_req.op = ALU_ADD;

        unique case (kind_reg)
            KIND_SUB: alu_req.op = ALU_SUB;
            KIND_DIV: alu_req.op = ALU_DIV;
            default:  alu_req.op = ALU_ADD;
        endcase

        if (state_reg == S_EXEC)
        begin
            commit = 1'b1;
            if (halted_reg)
            begin
                st_next = ST_HALT;
            end
            else
            begin
                unique case (kind_reg)
                    KIND_HALT:
                    begin
                        halt_set = 1'b1;
                        st_next  = ST_HALT;
                    end
                    KIND_PUSH_IMM, KIND_PUSH_REG:
                    begin
                        if (sp_reg == SP_W'(STACK_DEPTH))
                        begin
                            st_next = ST_OVER;
                        end
                        else
                        begin
                            mem_we   = 1'b1;
                            sp_next  = sp_reg + 1'b1;
                            top_next = push_val;
                        end
                    end
                    KIND_POP_REG, KIND_POP_DROP:
                    begin
                        if (sp_reg == '0)
                        begin
                            st_next = ST_UNDER;
                        end
                        else
                        begin
                            sp_next  = sp_reg - 1'b1;
                            gp_we    = (kind_reg == KIND_POP_REG)
                                    && (sel_reg < SEL_W'(NUM_REGS));
                            top_next = (sp_reg >= SP_W'(2)) ? next_rd_reg : '0;
                        end
                    end
                    KIND_ADD, KIND_SUB, KIND_DIV:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            st_next = ST_UNDER;
                        end
                        else if (kind_reg == KIND_DIV && next_rd_reg == '0)
                        begin
                            st_next = ST_DIVZ;
                        end
                        else
                        begin
                            commit = 1'b0;
                            go_alu = 1'b1;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
        end
        else if (state_reg == S_WB)
        begin
            commit    = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = addr_next;
            mem_wdata = alu_rsp.result;
            sp_next   = sp_reg - 1'b1;
            top_next  = alu_rsp.result;
        end

        alu_req.start = go_alu;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            top_rd_reg  <= stack_mem[addr_top];
            next_rd_reg <= stack_mem[addr_next];
        end
        if (mem_we && commit && out_free)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            kind_reg <= kind_t'(cmd.kind);
            sel_reg  <= cmd.reg_sel;
            imm_reg  <= cmd.immediate;
        end
        if (commit && out_free)
        begin
            rsp_top_reg    <= top_next;
            rsp_depth_reg  <= DEPTH_W'(sp_next);
            rsp_status_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                gp_reg[i] <= '0;
            end
        end
        else
        begin
            if (commit && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                sp_reg        <= sp_next;
                state_reg     <= S_IDLE;
                if (halt_set)
                begin
                    halted_reg <= 1'b1;
                end
                if (gp_we)
                begin
                    gp_reg[sel_reg] <= top_rd_reg;
                end
            end
            else
            begin
                if (rsp.ready)
                begin
                    rsp_valid_reg <= 1'b0;
                end
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (cmd_fire)
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                    S_EXEC:
                    begin
                        if (go_alu)
                        begin
                            state_reg <= S_ALU;
                        end
                    end
                    S_ALU:
                    begin
                        if (alu_rsp.done)
                        begin
                            state_reg <= S_WB;
                        end
                    end
                    S_WB:
                    begin
                        state_reg <= S_WB;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.top_value   = rsp_top_reg;
    assign rsp.stack_depth = rsp_depth_reg;
    assign rsp.status      = rsp_status_reg;

endmodule

// ===== dv/stack_machine_execute_tb.sv =====
`timescale 1ns / 1ps

module stack_machine_execute_tb import smx_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_REQUESTS = 1350;
    localparam int unsigned DRAIN_CYCLES = 60;

    typedef struct {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } step_result_t;

    class stack_scoreboard;
        logic [DATA_W-1:0] words [STACK_DEPTH];
        logic [DATA_W-1:0] regs [NUM_REGS];
        int unsigned       depth;
        bit                halted;
        step_result_t      pending [$];
        int unsigned       requests;
        int unsigned       results;
        int unsigned       mismatches;
        int unsigned       status_count [5];

        function new();
            foreach (words[i])
                words[i] = '0;
            foreach (regs[i])
                regs[i] = '0;
            foreach (status_count[i])
                status_count[i] = 0;
            depth = 0;
            halted = 1'b0;
            requests = 0;
            results = 0;
            mismatches = 0;
        endfunction

        function logic [DATA_W-1:0] truncated_quotient(logic [DATA_W-1:0] dividend,
                                                        logic [DATA_W-1:0] divisor);
            logic [DATA_W-1:0] num_mag;
            logic [DATA_W-1:0] den_mag;
            logic [DATA_W-1:0] quot;
            num_mag = dividend[DATA_W-1] ? -dividend : dividend;
            den_mag = divisor[DATA_W-1] ? -divisor : divisor;
            quot = num_mag / den_mag;
            return (dividend[DATA_W-1] != divisor[DATA_W-1]) ? -quot : quot;
        endfunction

        function void note_request(kind_t op, logic [SEL_W-1:0] sel, logic [DATA_W-1:0] imm);
            step_result_t      want;
            logic [DATA_W-1:0] top_w;
            logic [DATA_W-1:0] next_w;
            logic [DATA_W-1:0] value;
            status_t           st;
            st = ST_OK;
            requests++;
            if (halted)
            begin
                st = ST_HALT;
            end
            else
            begin
                case (op)
                    KIND_HALT:
                    begin
                        halted = 1'b1;
                        st = ST_HALT;
                    end
                    KIND_PUSH_IMM, KIND_PUSH_REG:
                    begin
                        if (depth >= STACK_DEPTH)
                        begin
                            st = ST_OVER;
                        end
                        else
                        begin
                            if (op == KIND_PUSH_IMM)
                                value = imm;
                            else
                                value = (sel < NUM_REGS) ? regs[sel] : '0;
                            words[depth] = value;
                            depth++;
                        end
                    end
                    KIND_POP_REG, KIND_POP_DROP:
                    begin
                        if (depth == 0)
                        begin
                            st = ST_UNDER;
                        end
                        else
                        begin
                            depth--;
                            if (op == KIND_POP_REG && sel < NUM_REGS)
                                regs[sel] = words[depth];
                        end
                    end
                    default:
                    begin
                        if (depth < 2)
                        begin
                            st = ST_UNDER;
                        end
                        else
                        begin
                            top_w = words[depth-1];
                            next_w = words[depth-2];
                            if (op == KIND_DIV && next_w == '0)
                            begin
                                st = ST_DIVZ;
                            end
                            else
                            begin
                                case (op)
                                    KIND_ADD: value = next_w + top_w;
                                    KIND_SUB: value = next_w - top_w;
                                    default:  value = truncated_quotient(top_w, next_w);
                                endcase
                                depth--;
                                words[depth-1] = value;
                            end
                        end
                    end
                endcase
            end
            want.top = (depth > 0) ? words[depth-1] : '0;
            want.depth = DEPTH_W'(depth);
            want.status = st;
            pending.push_back(want);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [DATA_W-1:0] top, logic [DEPTH_W-1:0] depth_seen,
                          logic [STATUS_W-1:0] status_seen);
            step_result_t want;
            results++;
            if (status_seen < 5)
                status_count[status_seen]++;
            if (pending.size() == 0)
            begin
                report($sformatf("result with no request waiting: top %h depth %0d status %0d",
                                 top, depth_seen, status_seen));
                return;
            end
            want = pending.pop_front();
            if (top !== want.top)
                report($sformatf("result %0d top_value %h, want %h", results, top, want.top));
            if (depth_seen !== want.depth)
                report($sformatf("result %0d stack_depth %0d, want %0d",
                                 results, depth_seen, want.depth));
            if (status_seen !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 results, status_seen, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned stall_left;
    stack_scoreboard sb;

    smx_cmd_if cmd_ch ();
    smx_rsp_if rsp_ch ();

    stack_machine_execute i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.top_value, rsp_ch.stack_depth, rsp_ch.status);
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                case ((cycle_count / 600) % 3)
                    1: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
                    2: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 12);
                    default: stall_left = 0;
                endcase
            end
        end
    end

    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic issue(kind_t op, logic [SEL_W-1:0] sel, logic [DATA_W-1:0] imm);
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= op;
        cmd_ch.reg_sel <= sel;
        cmd_ch.immediate <= imm;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(op, sel, imm);
        @(negedge clk);
        pace();
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: w = 32'h0000_0000;
                    1: w = 32'h0000_0001;
                    2: w = 32'hFFFF_FFFF;
                    3: w = 32'h8000_0000;
                    default: w = 32'h7FFF_FFFF;
                endcase
            end
            1: w = 32'($signed($urandom_range(0, 32)) - 16);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic push_word(logic [DATA_W-1:0] w);
        if ($urandom_range(0, 4) == 0)
            issue(KIND_PUSH_REG, SEL_W'($urandom_range(0, 3)), $urandom);
        else
            issue(KIND_PUSH_IMM, SEL_W'($urandom_range(0, 3)), w);
    endtask

    task automatic run_directed();
        issue(KIND_POP_DROP, 2'd0, '0);
        issue(KIND_POP_REG, 2'd1, '0);
        issue(KIND_ADD, 2'd0, '0);
        issue(KIND_PUSH_IMM, 2'd0, 32'h7FFF_FFFF);
        issue(KIND_SUB, 2'd0, '0);
        issue(KIND_DIV, 2'd0, '0);
        issue(KIND_PUSH_IMM, 2'd0, 32'h8000_0000);
        issue(KIND_ADD, 2'd0, '0);
        issue(KIND_PUSH_REG, 2'd0, '0);
        issue(KIND_PUSH_IMM, 2'd0, 32'd5);
        issue(KIND_DIV, 2'd0, '0);
        issue(KIND_POP_REG, 2'd1, '0);
        issue(KIND_POP_DROP, 2'd0, '0);
        issue(KIND_PUSH_IMM, 2'd0, 32'h8000_0000);
        issue(KIND_DIV, 2'd0, '0);
        issue(KIND_PUSH_IMM, 2'd0, 32'd7);
        issue(KIND_SUB, 2'd0, '0);
        issue(KIND_PUSH_IMM, 2'd0, -32'sd3);
        issue(KIND_PUSH_IMM, 2'd0, 32'd7);
        issue(KIND_DIV, 2'd0, '0);
        issue(KIND_PUSH_REG, 2'd3, '0);
        issue(KIND_POP_REG, 2'd3, '0);
        issue(KIND_PUSH_REG, 2'd1, '0);
        issue(KIND_POP_REG, 2'd2, '0);
        issue(KIND_PUSH_IMM, 2'd3, 32'hFFFF_FFFF);
    endtask

    task automatic run_random(int unsigned target);
        kind_t op;
        int unsigned n;
        while (sb.requests < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    op = kind_t'($urandom_range(KIND_ADD, KIND_DIV));
                    if (op == KIND_DIV)
                    begin
                        push_word(($urandom_range(0, 7) == 0) ? '0 : pick_word());
                        push_word(pick_word());
                    end
                    else
                    begin
                        n = $urandom_range(0, 2);
                        repeat (n) push_word(pick_word());
                    end
                    issue(op, SEL_W'($urandom_range(0, 3)), $urandom);
                end
                4:
                begin
                    issue(KIND_POP_REG, SEL_W'($urandom_range(0, 3)), $urandom);
                    if ($urandom_range(0, 1) == 0)
                        issue(KIND_PUSH_REG, SEL_W'($urandom_range(0, 3)), $urandom);
                end
                5:
                begin
                    while (sb.depth < STACK_DEPTH)
                        push_word(pick_word());
                    repeat ($urandom_range(1, 2)) push_word(pick_word());
                end
                6:
                begin
                    while (sb.depth > 0)
                    begin
                        op = ($urandom_range(0, 1) == 0) ? KIND_POP_DROP : KIND_POP_REG;
                        issue(op, SEL_W'($urandom_range(0, 3)), $urandom);
                    end
                    repeat ($urandom_range(1, 2))
                        issue(kind_t'($urandom_range(KIND_POP_REG, KIND_DIV)),
                              SEL_W'($urandom_range(0, 3)), $urandom);
                end
                7:
                begin
                    repeat ($urandom_range(1, 4))
                        issue(kind_t'($urandom_range(KIND_PUSH_IMM, KIND_DIV)),
                              SEL_W'($urandom_range(0, 3)), $urandom);
                end
                default:
                begin
                    repeat ($urandom_range(1, 3)) push_word(pick_word());
                end
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = KIND_POP_DROP;
        cmd_ch.reg_sel = '0;
        cmd_ch.immediate = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(sb.requests + RANDOM_REQUESTS);

        // halt is final: everything after it gets halted status and leaves the stack alone
        issue(KIND_HALT, SEL_W'($urandom_range(0, 3)), $urandom);
        repeat (3)
            issue(kind_t'($urandom_range(KIND_HALT, KIND_DIV)),
                  SEL_W'($urandom_range(0, 3)), $urandom);
        cmd_ch.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests over %0d cycles; %0d results checked, %0d mismatches.",
                 sb.requests, cycle_count, sb.results, sb.mismatches);
        $display("Status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, halted %0d.",
                 sb.status_count[0], sb.status_count[1], sb.status_count[2],
                 sb.status_count[3], sb.status_count[4]);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
